// ===== rtl/core/pgt_pkg.sv =====
// ----------------------------------------------------------------------------
// pgt_pkg
// shared constants, codes and control/status types of the gradient table unit
// ----------------------------------------------------------------------------
package pgt_pkg;

    // sizing
    localparam int MAX_GROUP_ENTRIES = 16;
    localparam int SCREEN_LINES      = 224;
    localparam int PALETTE_DEPTH     = 256;

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int J_W     = (MAX_GROUP_ENTRIES > 1) ? $clog2(MAX_GROUP_ENTRIES) : 1;
    localparam int E_W     = 5;
    localparam int IDX_W   = 8;
    localparam int COL_W   = 15;
    localparam int CH_W    = 5;
    localparam int CH_MAX  = 31;
    localparam int INT_W   = 14;
    localparam int RATE_W  = 12;
    localparam int LINE_W  = 9;
    localparam int CMP_W   = LINE_W + 1;
    localparam int FAC_W   = 10;
    localparam int FAC_SAT = 992;        // 31 * 32, any larger factor clamps anyway
    localparam int INT_MAX = 8191;
    localparam int INT_MIN = -8192;

    // divide by 31: floor(p * RECIP >> RECIP_SH), exact for p < 2^15
    localparam int RECIP    = 33826;
    localparam int RECIP_SH = 20;
    localparam int MUL_W    = 32;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int FUNC_W     = 2;

    // config port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 8;

    // func codes
    localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FN_EMIT    = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_FIRST  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ENTRY  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_STEP   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RATE   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MODE   = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;      // write palette word from input payload
        logic restart;   // clear intensity, rate and line counters
        logic start;     // begin a group: clear entry counter, snapshot factor
        logic rst_grp;   // group being started is the reset group
        logic issue;     // read one palette entry into the pipeline
        logic commit;    // advance line, rate and intensity after a full group
    } t_pgt_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_empty;  // no entry in the read or math stage
        logic pipe_en;     // pipeline may advance this cycle
        logic beyond;      // line position already at or past the height
        logic fits;        // a reset group still fits on screen
        logic hit;         // current entry reaches the height
        logic issue_end;   // current entry is the last of its group
        logic rmode;       // group in flight is the reset group
    } t_pgt_stat;

endpackage

// ===== rtl/core/pgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pgt_ctrl
// sequencer: takes input transfers, tracks the table phase, walks group entries
// ----------------------------------------------------------------------------
module pgt_ctrl
    import pgt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    output logic              o_in_ready,
    input  t_pgt_stat         i_stat,
    output t_pgt_cmd          o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } t_state;

    typedef enum logic [2:0] {
        PH_GEN   = 3'b001,
        PH_RESET = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_stat.pipe_empty;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FN_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        FN_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_phase       = PH_GEN;
                        end
                        FN_EMIT: begin
                            if (r_phase == PH_RESET) begin
                                o_cmd.start   = 1'b1;
                                o_cmd.rst_grp = 1'b1;
                                n_state       = ST_ISSUE;
                            end else if (r_phase == PH_GEN) begin
                                if (!i_stat.beyond) begin
                                    o_cmd.start = 1'b1;
                                    n_state     = ST_ISSUE;
                                end else if (i_stat.fits) begin
                                    o_cmd.start   = 1'b1;
                                    o_cmd.rst_grp = 1'b1;
                                    n_state       = ST_ISSUE;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = i_stat.pipe_en;
                if (i_stat.pipe_en && i_stat.issue_end) begin
                    n_state = ST_IDLE;
                    if (i_stat.rmode) begin
                        n_phase = PH_DONE;
                    end else if (i_stat.hit) begin
                        n_phase = i_stat.fits ? PH_RESET : PH_DONE;
                    end else begin
                        o_cmd.commit = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_GEN;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // nothing is read from the palette once the table has ended
    a_no_issue_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_phase != PH_DONE))
        else $error("entry issued after table end");

    // a commit closes a normal group, never the reset group
    a_commit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!i_stat.rmode && !i_stat.hit))
        else $error("commit on a group that ended the table");

    // the table end is left only through a restart
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) && !(accept && (i_func == FN_RESTART)) |=> (r_phase == PH_DONE))
        else $error("table end left without restart");

endmodule

// ===== rtl/core/pgt_dp.sv =====
// ----------------------------------------------------------------------------
// pgt_dp
// datapath: config registers, palette memory, counters and colour pipeline
// ----------------------------------------------------------------------------
module pgt_dp
    import pgt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_idx,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    // input payload
    input  logic [IN_DATA_W-1:0]  i_in_data,
    // control
    input  t_pgt_cmd              i_cmd,
    output t_pgt_stat             o_stat,
    // result stream
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last,
    output logic                  o_out_done
);

    // config registers
    logic [IDX_W-1:0]        r_first;
    logic [E_W-1:0]          r_entries;
    logic signed [5:0]       r_step;
    logic [7:0]              r_height;
    logic [2:0]              r_rate_sh;
    logic                    r_blend;

    // table state
    logic signed [INT_W-1:0] r_int, n_int;
    logic [RATE_W-1:0]       r_rate, n_rate;
    logic [LINE_W-1:0]       r_line;
    logic [J_W-1:0]          r_j;
    logic                    r_rmode;
    logic [FAC_W-1:0]        r_fac;
    logic signed [INT_W-1:0] r_add;

    // palette memory
    logic [COL_W-1:0]        mem [PALETTE_DEPTH];
    logic [PAL_AW-1:0]       rd_addr;

    // pipeline
    logic                    en;
    logic                    r_s1_valid, r_s1_last, r_s1_done, r_s1_rmode;
    logic [IDX_W-1:0]        r_s1_idx;
    logic [COL_W-1:0]        r_s1_col;
    logic                    r_s2_valid, r_s2_last, r_s2_done, r_s2_rmode;
    logic [IDX_W-1:0]        r_s2_idx;
    logic [COL_W-1:0]        r_s2_raw, r_s2_sum;
    logic [COL_W-1:0]        r_s2_prod [3];
    logic                    r_out_valid, r_out_last, r_out_done;
    logic [IDX_W-1:0]        r_out_idx;
    logic [COL_W-1:0]        r_out_col;

    logic [E_W-1:0]          eff_e;
    logic [IDX_W-1:0]        cur_idx;
    logic                    is_last, is_done;
    logic signed [INT_W:0]   fac_full;
    logic [FAC_W-1:0]        fac_sat;
    logic [COL_W-1:0]        sum_col, div_col, n_col;
    logic [COL_W-1:0]        prod [3];
    logic [RATE_W-1:0]       rate_sum, rate_thr;
    logic signed [INT_W:0]   int_sum;

    // effective group size
    always_comb begin
        if (r_entries == '0) begin
            eff_e = E_W'(1);
        end else if (int'(r_entries) > MAX_GROUP_ENTRIES) begin
            eff_e = E_W'(MAX_GROUP_ENTRIES);
        end else begin
            eff_e = r_entries;
        end
    end

    assign cur_idx = r_first + IDX_W'(r_j);
    assign rd_addr = cur_idx[PAL_AW-1:0];

    assign o_stat.pipe_empty = !r_s1_valid && !r_s2_valid;
    assign o_stat.pipe_en    = en;
    assign o_stat.beyond     = r_line >= LINE_W'(r_height);
    assign o_stat.fits       = ({1'b0, r_line} + CMP_W'(eff_e)) < CMP_W'(SCREEN_LINES);
    assign o_stat.hit        = ({1'b0, r_line} + CMP_W'(r_j) + CMP_W'(1))
                               >= CMP_W'(r_height);
    assign o_stat.issue_end  = (E_W'(r_j) + E_W'(1) == eff_e) || (!r_rmode && o_stat.hit);
    assign o_stat.rmode      = r_rmode;

    assign is_last = o_stat.issue_end;
    assign is_done = r_rmode ? o_stat.issue_end : (o_stat.hit && !o_stat.fits);

    // stall the whole pipeline while a result waits at the output
    assign en = !r_out_valid || i_out_ready;

    // factor 31 - intensity, clamped to 0..FAC_SAT
    always_comb begin
        fac_full = (INT_W+1)'(CH_MAX) - {r_int[INT_W-1], r_int};
        if (fac_full <= 0) begin
            fac_sat = '0;
        end else if (fac_full > (INT_W+1)'(FAC_SAT)) begin
            fac_sat = FAC_W'(FAC_SAT);
        end else begin
            fac_sat = fac_full[FAC_W-1:0];
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= '0;
            r_entries <= E_W'(1);
            r_step    <= '0;
            r_height  <= 8'(SCREEN_LINES);
            r_rate_sh <= '0;
            r_blend   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST:  r_first   <= i_cfg_data[IDX_W-1:0];
                CFG_ENTRY:  r_entries <= i_cfg_data[E_W-1:0];
                CFG_STEP:   r_step    <= i_cfg_data[5:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[7:0];
                CFG_RATE:   r_rate_sh <= i_cfg_data[2:0];
                CFG_MODE:   r_blend   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // counter advance after a full group
    always_comb begin
        rate_sum = r_rate + RATE_W'(eff_e);
        rate_thr = RATE_W'(eff_e) << r_rate_sh;
        n_rate   = rate_sum;
        n_int    = r_int;
        int_sum  = {r_int[INT_W-1], r_int} + (INT_W+1)'(r_step);
        if (rate_sum >= rate_thr) begin
            n_rate = rate_sum - rate_thr;
            if (int_sum > (INT_W+1)'(INT_MAX)) begin
                n_int = INT_W'(INT_MAX);
            end else if (int_sum < (INT_W+1)'(INT_MIN)) begin
                n_int = INT_W'(INT_MIN);
            end else begin
                n_int = int_sum[INT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int   <= '0;
            r_rate  <= '0;
            r_line  <= '0;
            r_j     <= '0;
            r_rmode <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_int  <= '0;
                r_rate <= '0;
                r_line <= '0;
            end else if (i_cmd.commit) begin
                r_int  <= n_int;
                r_rate <= n_rate;
                r_line <= r_line + LINE_W'(eff_e);
            end
            if (i_cmd.start) begin
                r_j     <= '0;
                r_rmode <= i_cmd.rst_grp;
            end else if (i_cmd.issue) begin
                r_j <= r_j + J_W'(1);
            end
        end
    end

    // per-group snapshot, stable while entries of the group are in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_fac <= fac_sat;
            r_add <= r_int;
        end
    end

    // palette memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[i_in_data[PAL_AW-1:0]] <= i_in_data[IDX_W +: COL_W];
        end
        if (en && i_cmd.issue) begin
            r_s1_col <= mem[rd_addr];
        end
    end

    // stage 1: palette word read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_cmd.issue) begin
            r_s1_idx   <= cur_idx;
            r_s1_last  <= is_last;
            r_s1_done  <= is_done;
            r_s1_rmode <= r_rmode;
        end
    end

    // stage 2: channel products and offsets
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [CH_W-1:0]       c;
            logic signed [INT_W:0] sv;
            c       = r_s1_col[k*CH_W +: CH_W];
            prod[k] = COL_W'(c) * COL_W'(r_fac);
            sv      = $signed({{(INT_W+1-CH_W){1'b0}}, c}) + {r_add[INT_W-1], r_add};
            if (sv < 0) begin
                sum_col[k*CH_W +: CH_W] = '0;
            end else if (sv > (INT_W+1)'(CH_MAX)) begin
                sum_col[k*CH_W +: CH_W] = CH_W'(CH_MAX);
            end else begin
                sum_col[k*CH_W +: CH_W] = sv[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_idx   <= r_s1_idx;
            r_s2_last  <= r_s1_last;
            r_s2_done  <= r_s1_done;
            r_s2_rmode <= r_s1_rmode;
            r_s2_raw   <= r_s1_col;
            r_s2_sum   <= sum_col;
            for (int k = 0; k < 3; k++) begin
                r_s2_prod[k] <= prod[k];
            end
        end
    end

    // stage 3: divide by 31 through reciprocal, clamp, select
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [MUL_W-1:0]          mq;
            logic [MUL_W-RECIP_SH-1:0] qv;
            mq = MUL_W'(r_s2_prod[k]) * MUL_W'(RECIP);
            qv = mq[MUL_W-1:RECIP_SH];
            if (qv > (MUL_W-RECIP_SH)'(CH_MAX)) begin
                div_col[k*CH_W +: CH_W] = CH_W'(CH_MAX);
            end else begin
                div_col[k*CH_W +: CH_W] = qv[CH_W-1:0];
            end
        end
        if (r_s2_rmode) begin
            n_col = r_s2_raw;
        end else if (r_blend) begin
            n_col = r_s2_sum;
        end else begin
            n_col = div_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid) begin
            r_out_idx  <= r_s2_idx;
            r_out_col  <= n_col;
            r_out_last <= r_s2_last;
            r_out_done <= r_s2_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {(OUT_DATA_W-IDX_W-COL_W)'(0), r_out_col, r_out_idx};
    assign o_out_last  = r_out_last;
    assign o_out_done  = r_out_done;

    // end of table always closes a group
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("table end without group end");

    // a group starts only on an empty pipeline, so the snapshot is safe
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (!r_s1_valid && !r_s2_valid))
        else $error("group started with entries in flight");

    // a stalled entry in the read stage is not lost
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !en |=> r_s1_valid)
        else $error("read stage entry dropped under stall");

endmodule

// ===== rtl/core/palette_gradient_table_gen_unit.sv =====
// first result of a generate transfer passes the issue state, then the palette read, product and output registers
// a generate transfer is paced by the single palette read port walking one entry
//   per cycle while the output does not stall, plus the two-stage colour pipeline
//   that drains before the next transfer is accepted
// reset: synchronous active low, clears counters, phase and config; palette kept
// ----------------------------------------------------------------------------
// palette_gradient_table_gen_unit
// rgb555 fade gradient table generator, one line group per generate transfer
// ----------------------------------------------------------------------------
module palette_gradient_table_gen_unit
    import pgt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_idx,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // load_index[7:0], load_colour[22:8]
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pal_index[7:0], colour_out[22:8]
    output logic                  m_axis_tlast,   // group_last
    output logic                  m_axis_tuser    // table_done[0]
);

    // command and status between sequencer and datapath
    t_pgt_cmd  cmd;
    t_pgt_stat stat;

    // sequencer: accepts a transfer only when idle with an empty pipeline
    pgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: palette memory, counters, colour math and output register
    pgt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_done  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/palette_gradient_table_gen_unit_tb.sv =====
// ----------------------------------------------------------------------------
// palette_gradient_table_gen_unit_tb
// self-checking bench: palette loads, table restarts and group emits go in on
// the input stream, every emitted table entry is checked against a predictor
// ----------------------------------------------------------------------------
module palette_gradient_table_gen_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgt_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;   // no function, ignored by the unit
    localparam int RANDOM_ITEMS = 180;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 24;                  // one full group plus pipeline drain
    localparam int HOLD_OFF     = 400;                 // long receiver back-pressure stretch

    typedef enum logic [1:0] {
        TBL_GENERATING,
        TBL_RESET_GROUP,
        TBL_FINISHED
    } t_table_phase;

    typedef struct packed {
        logic [IDX_W-1:0] pal_index;
        logic [COL_W-1:0] colour;
        logic             group_last;
        logic             table_done;
    } t_gradient_entry;

    // ------------------------------------------------------------------------
    // gradient predictor and entry checker
    // ------------------------------------------------------------------------
    class gradient_scoreboard;
        t_gradient_entry  expected_entries[$];
        logic [COL_W-1:0] palette [PALETTE_DEPTH];
        bit               loaded  [PALETTE_DEPTH];
        int               intensity;
        int               rate_count;
        int               line_pos;
        t_table_phase     tbl_phase;
        logic [IDX_W-1:0] first_idx;
        logic [E_W-1:0]   entries_reg;
        int               step_reg;
        int               height_reg;
        int               rate_reg;
        bit               blend_reg;
        int               failures;
        int               reported;

        function new();
            foreach (loaded[i]) begin
                loaded[i]  = 1'b0;
                palette[i] = '0;
            end
            intensity   = 0;
            rate_count  = 0;
            line_pos    = 0;
            tbl_phase   = TBL_GENERATING;
            first_idx   = '0;
            entries_reg = 5'd1;
            step_reg    = 0;
            height_reg  = SCREEN_LINES;
            rate_reg    = 0;
            blend_reg   = 1'b0;
            failures    = 0;
            reported    = 0;
        endfunction

        // out-of-range group sizes fold into 1..MAX_GROUP_ENTRIES
        function int group_size();
            if (entries_reg == 0) return 1;
            if (entries_reg > MAX_GROUP_ENTRIES) return MAX_GROUP_ENTRIES;
            return int'(entries_reg);
        endfunction

        function void note_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_FIRST:  first_idx   = val[IDX_W-1:0];
                CFG_ENTRY:  entries_reg = val[E_W-1:0];
                CFG_STEP:   step_reg    = int'($signed(val[5:0]));
                CFG_HEIGHT: height_reg  = int'(val);
                CFG_RATE:   rate_reg    = int'(val[2:0]);
                CFG_MODE:   blend_reg   = val[0];
                default: ;
            endcase
        endfunction

        // mode 0 scales toward black, mode 1 adds the intensity; clamp to 0..31
        function logic [CH_W-1:0] fade_channel(logic [CH_W-1:0] c);
            int v;
            if (!blend_reg) begin
                if (31 - intensity <= 0) return '0;
                v = (int'(c) * (31 - intensity)) / 31;
            end else begin
                v = int'(c) + intensity;
            end
            if (v < 0) v = 0;
            if (v > CH_MAX) v = CH_MAX;
            return v[CH_W-1:0];
        endfunction

        function void add_entry(int j, logic [COL_W-1:0] col, bit last, bit done);
            t_gradient_entry ent;
            ent.pal_index  = IDX_W'(first_idx + j);
            ent.colour     = col;
            ent.group_last = last;
            ent.table_done = done;
            expected_entries.push_back(ent);
        endfunction

        // closing group: original colours, marks the end of the table
        function void push_reset_group(int e);
            for (int j = 0; j < e; j++)
                add_entry(j, palette[IDX_W'(first_idx + j)], j + 1 == e, j + 1 == e);
            tbl_phase = TBL_FINISHED;
        endfunction

        function void predict_group();
            int               e;
            int               thr;
            bit               fits;
            logic [COL_W-1:0] c;
            logic [COL_W-1:0] col;
            e    = group_size();
            fits = (line_pos + e) < SCREEN_LINES;
            if (tbl_phase == TBL_RESET_GROUP) begin
                push_reset_group(e);
                return;
            end
            if (tbl_phase != TBL_GENERATING) return;
            // height already passed: end at once, reset group only if it fits
            if (line_pos >= height_reg) begin
                if (fits) push_reset_group(e);
                else tbl_phase = TBL_FINISHED;
                return;
            end
            for (int j = 0; j < e; j++) begin
                c   = palette[IDX_W'(first_idx + j)];
                col = {fade_channel(c[14:10]), fade_channel(c[9:5]), fade_channel(c[4:0])};
                // entry reaching the height cuts the group short
                if (line_pos + j + 1 >= height_reg) begin
                    add_entry(j, col, 1'b1, !fits);
                    tbl_phase = fits ? TBL_RESET_GROUP : TBL_FINISHED;
                    return;
                end
                add_entry(j, col, j + 1 == e, 1'b0);
            end
            line_pos   = (line_pos + e) & 'h1ff;
            rate_count = (rate_count + e) & 'hfff;
            thr        = e << rate_reg;
            if (rate_count >= thr) begin
                rate_count = rate_count - thr;
                intensity  = intensity + step_reg;
                if (intensity > INT_MAX) intensity = INT_MAX;
                if (intensity < INT_MIN) intensity = INT_MIN;
            end
        endfunction

        function void note_transfer(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                    logic [COL_W-1:0] col);
            case (fn)
                FN_LOAD: begin
                    palette[idx] = col;
                    loaded[idx]  = 1'b1;
                end
                FN_RESTART: begin
                    intensity  = 0;
                    rate_count = 0;
                    line_pos   = 0;
                    tbl_phase  = TBL_GENERATING;
                end
                FN_EMIT: predict_group();
                default: ;
            endcase
        endfunction

        function void check_result(t_gradient_entry got);
            t_gradient_entry want;
            if (expected_entries.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected entry: index %0d colour %h last %b done %b",
                             got.pal_index, got.colour, got.group_last, got.table_done);
                end
                return;
            end
            want = expected_entries.pop_front();
            if (got.pal_index != want.pal_index || got.colour != want.colour ||
                got.group_last != want.group_last || got.table_done != want.table_done) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display({"entry mismatch: want index %0d colour %h last %b done %b,",
                              " got %0d %h %b %b"},
                             want.pal_index, want.colour, want.group_last, want.table_done,
                             got.pal_index, got.colour, got.group_last, got.table_done);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut and shared counters
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_AW-1:0]     i_cfg_idx;
    logic [CFG_DW-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // load_index[7:0], load_colour[22:8]
    logic [FUNC_W-1:0]     s_axis_tuser;    // func[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // pal_index[7:0], colour_out[22:8]
    logic                  m_axis_tlast;    // group_last
    logic                  m_axis_tuser;    // table_done[0]

    gradient_scoreboard sb;
    int  cycle_count     = 0;
    int  transfers_sent  = 0;
    int  results_seen    = 0;
    int  tables_done     = 0;
    int  settings_used   = 0;
    bit  held_off        = 1'b0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    palette_gradient_table_gen_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // input side: one transfer per call, random gap in front of it
    // ------------------------------------------------------------------------
    task automatic send_item(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                             logic [COL_W-1:0] col);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = fn;
        s_axis_tdata  = {1'b0, col, idx};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_transfer(fn, idx, col);
        transfers_sent++;
    endtask

    // a group only reads loaded palette entries: fill any hole in its window first
    task automatic emit_group();
        int               e;
        logic [IDX_W-1:0] addr;
        e = sb.group_size();
        for (int j = 0; j < e; j++) begin
            addr = IDX_W'(sb.first_idx + j);
            if (!sb.loaded[addr]) send_item(FN_LOAD, addr, COL_W'($urandom));
        end
        send_item(FN_EMIT, IDX_W'($urandom), COL_W'($urandom));
    endtask

    // registers change only with the unit idle: all entries out, pipeline drained
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.note_register(idx, val);
    endtask

    task automatic configure_table(int first, int entries, int step, int height,
                                   int rate, int mode, bit restart);
        write_reg(CFG_FIRST,  CFG_DW'(first));
        write_reg(CFG_ENTRY,  CFG_DW'(entries));
        write_reg(CFG_STEP,   {2'b00, 6'(step)});
        write_reg(CFG_HEIGHT, CFG_DW'(height));
        write_reg(CFG_RATE,   CFG_DW'(rate));
        write_reg(CFG_MODE,   CFG_DW'(mode));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings_used++;
        if (restart) send_item(FN_RESTART, IDX_W'($urandom), COL_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // output side: ready pattern in stretches, one long hold-off to back up
    // the unit and stall its input
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int stretch_left;
        int style;
        int r;
        hold_left     = 0;
        stretch_left  = 0;
        style         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= 50) begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(4, 40);
                    r            = $urandom_range(0, 99);
                    style        = (r < 50) ? 0 : (r < 88) ? 1 : 2;
                end
                stretch_left--;
                case (style)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 3) != 0);
                    default: m_axis_tready = 1'b0;
                endcase
            end
        end
    end

    // result transfers are checked as they are accepted
    always @(posedge i_clk) begin : entry_monitor
        t_gradient_entry got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pal_index  = m_axis_tdata[7:0];
            got.colour     = m_axis_tdata[22:8];
            got.group_last = m_axis_tlast;
            got.table_done = m_axis_tuser;
            sb.check_result(got);
            results_seen++;
            if (m_axis_tuser) tables_done++;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("[palette_gradient_table_gen_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int directed_sent;
        int phase_no;
        int steps;
        int r;
        int first;
        int entries;
        int step;
        int height;
        int rate;
        int mode;
        int eff;
        bit restart;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, the ignored code, one group at reset settings
        send_item(FN_LOAD, 8'd0, 15'h7fff);
        send_item(FN_LOAD, 8'd255, 15'h0000);
        send_item(FN_UNUSED, 8'hff, 15'h7fff);
        emit_group();

        // index wrap past 255, large intensity kills every channel in mode 0,
        // short height then reset group, then an emit after the table end
        settle();
        configure_table(255, 2, 31, 3, 0, 0, 1'b1);
        repeat (4) emit_group();

        // zero height: reset group straight away, nothing after it
        settle();
        configure_table(255, 2, -31, 0, 7, 1, 1'b1);
        repeat (2) emit_group();

        // additive mode with big intensity clamps every channel high
        settle();
        configure_table(255, 2, 31, 4, 0, 1, 1'b1);
        repeat (3) emit_group();
        directed_sent = transfers_sent;

        // random settings, mostly complete tables with random content
        phase_no = 0;
        while (transfers_sent - directed_sent < RANDOM_ITEMS) begin
            case (phase_no)
                // full screen height: last generated entry ends the table
                0: begin
                    first = 250; entries = 16; step = -31; height = 224;
                    rate = 1; mode = 1; restart = 1'b1;
                end
                // oversize group register, reset group still fits
                1: begin
                    first = 0; entries = 31; step = 31; height = 200;
                    rate = 0; mode = 0; restart = 1'b1;
                end
                // zero group register acts as one entry
                2: begin
                    first = 128; entries = 0; step = -5; height = 1;
                    rate = 3; mode = 1; restart = 1'b1;
                end
                default: begin
                    r     = $urandom_range(0, 99);
                    first = (r < 15) ? 0 : (r < 30) ? 255 : $urandom_range(0, 255);
                    r       = $urandom_range(0, 99);
                    entries = (r < 10) ? 0 : (r < 18) ? $urandom_range(17, 31) :
                              (r < 30) ? 16 : $urandom_range(1, 8);
                    r    = $urandom_range(0, 99);
                    step = (r < 15) ? -31 : (r < 30) ? 31 : $urandom_range(0, 62) - 31;
                    eff  = (entries == 0) ? 1 : (entries > MAX_GROUP_ENTRIES) ?
                           MAX_GROUP_ENTRIES : entries;
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        height = 0;
                    end else if (r < 20) begin
                        // long tables only with wide groups to keep them short
                        height  = $urandom_range(200, 224);
                        entries = 16;
                    end else begin
                        height = $urandom_range(1, (eff * 10 > 224) ? 224 : eff * 10);
                    end
                    rate    = $urandom_range(0, 7);
                    mode    = $urandom_range(0, 1);
                    // without a restart the table continues under new settings
                    restart = ($urandom_range(0, 99) < 85);
                end
            endcase
            settle();
            configure_table(first, entries, step, height, rate, mode, restart);

            steps = 0;
            while (steps < 48 && sb.tbl_phase != TBL_FINISHED &&
                   transfers_sent - directed_sent < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    emit_group();
                else if (r < 93)
                    send_item(FN_LOAD, IDX_W'($urandom), COL_W'($urandom));
                else if (r < 96)
                    send_item(FN_RESTART, IDX_W'($urandom), COL_W'($urandom));
                else
                    send_item(FN_UNUSED, IDX_W'($urandom), COL_W'($urandom));
                steps++;
            end
            // an emit after the end must stay silent
            if (sb.tbl_phase == TBL_FINISHED && $urandom_range(0, 1)) emit_group();
            phase_no++;
        end

        // drain everything still expected, then give the pipeline time to spill
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_entries.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        sb.failures += sb.expected_entries.size();

        $display("run covered %0d input transfers (%0d directed), %0d table entries out",
                 transfers_sent, directed_sent, results_seen);
        $display("%0d register settings, %0d tables completed, receiver hold-off %0s",
                 settings_used, tables_done, held_off ? "done" : "not reached");
        if (sb.failures == 0) begin
            $display("[palette_gradient_table_gen_unit] OK");
        end else begin
            $display("[palette_gradient_table_gen_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pgt_pkg.sv
rtl/core/pgt_ctrl.sv
rtl/core/pgt_dp.sv
rtl/core/palette_gradient_table_gen_unit.sv
tb/sv/palette_gradient_table_gen_unit_tb.sv
